// ===== src/pbrr_pkg.sv =====
// package for the page buffer table: sizes, field widths and status codes
// no dependencies
`timescale 1ns / 1ps
package pbrr_pkg;
   localparam int NumBuffers = 64;
   localparam int PageBytes  = 8192;
   localparam int PinBits    = 16;
   localparam int IdxBits    = $clog2(NumBuffers);
   localparam int OffBits    = $clog2(PageBytes);
   localparam int PageBits   = 19;
   localparam int AddrBits   = 19;

   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_UNPIN  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_UNPINNED   = 3'd1,
      ST_BAD_INDEX  = 3'd2,
      ST_ALL_PINNED = 3'd3,
      ST_OVERFLOW   = 3'd4
   } status_type;
endpackage

// ===== src/page_buffer_pin_round_robin_evict_top.sv =====
// page buffer table top level: tag lookup, round-robin victim scan, pin counts
// depends on pbrr_pkg
// unpin, unknown kinds and hits respond from the lookup state; misses run the victim scan,
// which steps 1..NumBuffers entries; all pinned ends the scan after NumBuffers entries
// one request at a time; busy is high from start until rsp_valid; the receiver cannot stall
// synchronous reset clears all tags, dirty marks, pin counts and the victim pointer
`timescale 1ns / 1ps
module page_buffer_pin_round_robin_evict_top
   import pbrr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_kind,
   input  logic [31:0]         req_seg_id,
   input  logic [31:0]         req_seg_offset,
   input  logic [6:0]          req_unpin_index,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic                rsp_hit,
   output logic [5:0]          rsp_buf_index,
   output logic [18:0]         rsp_byte_address,
   output logic                rsp_fill_needed,
   output logic                rsp_evict_valid,
   output logic                rsp_victim_dirty,
   output logic [31:0]         rsp_victim_seg_id,
   output logic [18:0]         rsp_victim_page_id
);
   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SCAN} state_type;

   state_type               state_ff;
   logic [31:0]             tseg_ff [NumBuffers];
   logic [PageBits-1:0]     tpage_ff [NumBuffers];
   logic [NumBuffers-1:0]   dirty_ff;
   logic [PinBits-1:0]      pin_ff [NumBuffers];
   logic [IdxBits-1:0]      vptr_ff;
   logic [IdxBits-1:0]      scan_ff;
   logic [IdxBits:0]        cnt_ff;
   logic [1:0]              kind_ff;
   logic [31:0]             seg_ff;
   logic [31:0]             off_ff;
   logic [6:0]              uidx_ff;

   logic [NumBuffers-1:0]   match;
   logic                    have;
   logic [IdxBits-1:0]      found;
   logic [PageBits-1:0]     req_page;
   logic [AddrBits-1:0]     addr_in;
   logic [IdxBits-1:0]      idx_sel;
   localparam logic [PinBits-1:0] PinMax = '1;

   assign req_page = PageBits'(off_ff >> OffBits);

   always_comb begin
      for (int i = 0; i < NumBuffers; i++) begin
         match[i] = (tseg_ff[i] != 32'd0) && (tseg_ff[i] == seg_ff)
                    && (tpage_ff[i] == req_page);
      end
   end

   always_comb begin
      have  = 1'b0;
      found = '0;
      for (int i = NumBuffers - 1; i >= 0; i--) begin
         if (match[i]) begin
            have  = 1'b1;
            found = IdxBits'(i);
         end
      end
   end

   assign idx_sel = (state_ff == S_SCAN) ? scan_ff : found;
   assign addr_in = AddrBits'({idx_sel, off_ff[OffBits-1:0]});
   assign busy    = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      rsp_valid <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         vptr_ff  <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < NumBuffers; i++) begin
            tseg_ff[i]  <= '0;
            tpage_ff[i] <= '0;
            pin_ff[i]   <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  kind_ff  <= req_kind;
                  seg_ff   <= req_seg_id;
                  off_ff   <= req_seg_offset;
                  uidx_ff  <= req_unpin_index;
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               rsp_status         <= ST_OK;
               rsp_hit            <= 1'b0;
               rsp_buf_index      <= '0;
               rsp_byte_address   <= '0;
               rsp_fill_needed    <= 1'b0;
               rsp_evict_valid    <= 1'b0;
               rsp_victim_dirty   <= 1'b0;
               rsp_victim_seg_id  <= '0;
               rsp_victim_page_id <= '0;
               state_ff           <= S_IDLE;
               if (kind_ff == KIND_UNPIN) begin
                  rsp_valid     <= 1'b1;
                  rsp_buf_index <= uidx_ff[5:0];
                  if (32'(uidx_ff) >= 32'(NumBuffers)) begin
                     rsp_status <= ST_BAD_INDEX;
                  end else if (pin_ff[uidx_ff[IdxBits-1:0]] == '0) begin
                     rsp_status <= ST_UNPINNED;
                  end else begin
                     pin_ff[uidx_ff[IdxBits-1:0]] <= pin_ff[uidx_ff[IdxBits-1:0]] - 1'b1;
                  end
               end else if (kind_ff == KIND_NONE) begin
                  rsp_valid <= 1'b1;
               end else if (have) begin
                  rsp_valid        <= 1'b1;
                  rsp_hit          <= 1'b1;
                  rsp_buf_index    <= 6'(found);
                  rsp_byte_address <= addr_in;
                  if (kind_ff == KIND_READ) begin
                     if (pin_ff[found] == PinMax) rsp_status <= ST_OVERFLOW;
                     else pin_ff[found] <= pin_ff[found] + 1'b1;
                  end else begin
                     dirty_ff[found] <= 1'b1;
                  end
               end else begin
                  scan_ff  <= vptr_ff;
                  cnt_ff   <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (pin_ff[scan_ff] == '0) begin
                  rsp_valid        <= 1'b1;
                  rsp_buf_index    <= 6'(scan_ff);
                  rsp_byte_address <= addr_in;
                  rsp_fill_needed  <= 1'b1;
                  if (tseg_ff[scan_ff] != 32'd0) begin
                     rsp_evict_valid    <= 1'b1;
                     rsp_victim_dirty   <= dirty_ff[scan_ff];
                     rsp_victim_seg_id  <= tseg_ff[scan_ff];
                     rsp_victim_page_id <= tpage_ff[scan_ff];
                  end
                  tseg_ff[scan_ff]  <= seg_ff;
                  tpage_ff[scan_ff] <= req_page;
                  dirty_ff[scan_ff] <= (kind_ff == KIND_APPEND);
                  if (kind_ff == KIND_READ) pin_ff[scan_ff] <= PinBits'(1);
                  vptr_ff  <= IdxBits'((32'(scan_ff) + 1) % NumBuffers);
                  state_ff <= S_IDLE;
               end else if (32'(cnt_ff) == NumBuffers - 1) begin
                  rsp_valid  <= 1'b1;
                  rsp_status <= ST_ALL_PINNED;
                  state_ff   <= S_IDLE;
               end else begin
                  scan_ff <= IdxBits'((32'(scan_ff) + 1) % NumBuffers);
                  cnt_ff  <= cnt_ff + 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_resp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while still busy");
   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted start did not set busy");
   a_fill_not_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_fill_needed && rsp_hit)) else $error("fill on a hit");
endmodule
